// ----- rtl/core/tdc_pkg.sv -----
// shared types, constants and control structs for the tdc distance block
`default_nettype none
package tdc_pkg;
  localparam int unsigned TABLE_ENTRIES = 32;
  localparam int unsigned IDX_W = 5;
  localparam int unsigned TIME_W = 31;
  localparam int unsigned DIST_W = 24;
  localparam logic [23:0] TOF_SCALE = 24'd9000000;
  localparam int unsigned QUOT_W = 56;

  localparam logic [2:0] RC_OK = 3'd0;
  localparam logic [2:0] RC_OVERFLOW = 3'd1;
  localparam logic [2:0] RC_NO_TIME = 3'd2;
  localparam logic [2:0] RC_OUTSIDE = 3'd3;
  localparam logic [2:0] RC_ZERO_DIV = 3'd4;

  localparam logic [3:0] ST_OVERFLOW = 4'h2;
  localparam logic [3:0] ST_NEW = 4'h1;

  typedef enum logic [3:0] {
    S_IDLE, S_MUL, S_DIV, S_AVG, S_SCAN, S_SCAN_WAIT, S_FETCH, S_FETCH_WAIT,
    S_PROD, S_DIV2, S_DONE
  } state_t;

  // divider handshake
  typedef struct packed {
    logic start;
    logic [QUOT_W-1:0] dividend;
    logic [31:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic done;
    logic [QUOT_W-1:0] quotient;
  } div_rsp_t;
endpackage
`default_nettype wire

// ----- rtl/core/tdc_tof_to_distance_lut.sv -----
// top level: time-of-flight conversion with calibration table interpolation
// usage: raise start with the in_ fields while busy is low; the transaction
// is taken at that edge and busy stays high until its result is delivered.
// in_op = 0 writes one table slot; in_op = 1 converts one converter reading:
// a 56-step restoring divider forms the flight time, then the table is
// walked slot by slot, S_SCAN then S_SCAN_WAIT, through the single read
// port of the memory, then the two bracketing slots are fetched and a
// second 56-step division interpolates. a load, an overflow or a missing
// measurement goes from S_IDLE straight to S_DONE; a zero divisor ends
// after S_MUL, a nonpositive time after the first division, a time outside
// the table after the scan and a full conversion after the second division.
// out_valid is raised from S_DONE and busy drops the cycle after it, so a
// new transaction waits for the last result. one item is worked on at a time.
// out_valid is high for exactly one cycle with the result; the receiver
// cannot hold it off, so nothing waits behind it.
// reset clears the control state only; the table holds no defined value
// until loaded and every slot must be loaded before measuring.
`default_nettype none
module tdc_tof_to_distance_lut (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic busy,
  input  wire logic in_op,
  input  wire logic [4:0] in_entry_index,
  input  wire logic [30:0] in_entry_flight_time,
  input  wire logic [23:0] in_entry_distance,
  input  wire logic [3:0] in_irq_status,
  input  wire logic [23:0] in_time_count,
  input  wire logic [23:0] in_cal_count_one,
  input  wire logic [23:0] in_cal_count_two,
  output logic out_valid,
  output logic [2:0] out_result_code,
  output logic [24:0] out_distance_mm,
  output logic [4:0] out_segment,
  output logic signed [28:0] out_flight_time_ps
);
  localparam int unsigned IW = tdc_pkg::IDX_W;
  localparam int unsigned TW = tdc_pkg::TIME_W;
  localparam int unsigned DW = tdc_pkg::DIST_W;
  localparam int unsigned QW = tdc_pkg::QUOT_W;

  tdc_pkg::state_t state_r, state_nxt;
  tdc_pkg::div_req_t dreq;
  tdc_pkg::div_rsp_t drsp;

  logic [23:0] tcount_r, tcount_nxt;
  logic [31:0] divisor_r, divisor_nxt;
  logic [47:0] prod_r, prod_nxt;
  logic signed [28:0] tof_r, tof_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [IW-1:0] best_r, best_nxt;
  logic found_r, found_nxt;
  logic [TW-1:0] prev_t_r, prev_t_nxt;
  logic [TW-1:0] tlo_r, tlo_nxt, thi_r, thi_nxt;
  logic [DW-1:0] dlo_r, dlo_nxt, dhi_r, dhi_nxt;
  logic phase_r, phase_nxt;
  logic [2:0] code_r, code_nxt;
  logic [24:0] dist_r, dist_nxt;
  logic [4:0] seg_r, seg_nxt;
  logic valid_r, valid_nxt;

  logic wr_en;
  logic [IW-1:0] rd_addr;
  logic [TW-1:0] rd_time;
  logic [DW-1:0] rd_dist;
  logic [31:0] low32;
  logic signed [31:0] sval;
  logic [DW-1:0] dspan;
  logic [TW-1:0] part, tspan;
  logic [54:0] iprod;

  assign wr_en = start && !busy && !in_op;

  tdc_table_ram u_ram (
    .clk(clk), .wr_en(wr_en), .wr_addr(in_entry_index),
    .wr_time(in_entry_flight_time), .wr_dist(in_entry_distance),
    .rd_addr(rd_addr), .rd_time(rd_time), .rd_dist(rd_dist)
  );

  tdc_divider u_div (.clk(clk), .rst_n(rst_n), .req(dreq), .rsp(drsp));

  assign low32 = drsp.quotient[31:0];
  assign sval = $signed(low32);
  assign dspan = (dhi_r >= dlo_r) ? (dhi_r - dlo_r) : (dlo_r - dhi_r);
  assign part = TW'(tof_r) - tlo_r;
  assign tspan = thi_r - tlo_r;
  assign iprod = 55'(dspan) * 55'(part);

  always_comb begin
    state_nxt = state_r;
    tcount_nxt = tcount_r;
    divisor_nxt = divisor_r;
    prod_nxt = prod_r;
    tof_nxt = tof_r;
    idx_nxt = idx_r;
    best_nxt = best_r;
    found_nxt = found_r;
    prev_t_nxt = prev_t_r;
    tlo_nxt = tlo_r;
    thi_nxt = thi_r;
    dlo_nxt = dlo_r;
    dhi_nxt = dhi_r;
    phase_nxt = phase_r;
    code_nxt = code_r;
    dist_nxt = dist_r;
    seg_nxt = seg_r;
    valid_nxt = 1'b0;
    dreq = '0;
    rd_addr = idx_r;
    unique case (state_r)
      tdc_pkg::S_IDLE: begin
        if (start && !busy) begin
          code_nxt = tdc_pkg::RC_OK;
          dist_nxt = '0;
          seg_nxt = '0;
          tof_nxt = '0;
          tcount_nxt = in_time_count;
          // difference times sixteen, kept modulo 2^32
          divisor_nxt = {(28'(in_cal_count_two) - 28'(in_cal_count_one)), 4'b0};
          if (!in_op) begin
            state_nxt = tdc_pkg::S_DONE;
          end else if ((in_irq_status & tdc_pkg::ST_OVERFLOW) != 4'h0) begin
            code_nxt = tdc_pkg::RC_OVERFLOW;
            state_nxt = tdc_pkg::S_DONE;
          end else if ((in_irq_status & tdc_pkg::ST_NEW) == 4'h0) begin
            code_nxt = tdc_pkg::RC_NO_TIME;
            state_nxt = tdc_pkg::S_DONE;
          end else begin
            state_nxt = tdc_pkg::S_MUL;
          end
        end
      end
      tdc_pkg::S_MUL: begin
        prod_nxt = 48'(tcount_r) * 48'(tdc_pkg::TOF_SCALE);
        if (divisor_r == 32'd0) begin
          code_nxt = tdc_pkg::RC_ZERO_DIV;
          state_nxt = tdc_pkg::S_DONE;
        end else begin
          state_nxt = tdc_pkg::S_DIV;
          phase_nxt = 1'b0;
        end
      end
      tdc_pkg::S_DIV: begin
        if (!phase_r) begin
          dreq.start = 1'b1;
          dreq.dividend = QW'(prod_r);
          dreq.divisor = divisor_r;
          phase_nxt = 1'b1;
        end else if (drsp.done) begin
          // truncating divide by eight
          tof_nxt = 29'((sval + (sval[31] ? 32'sd7 : 32'sd0)) >>> 3);
          state_nxt = tdc_pkg::S_AVG;
        end
      end
      tdc_pkg::S_AVG: begin
        if (tof_r <= 29'sd0) begin
          code_nxt = tdc_pkg::RC_NO_TIME;
          state_nxt = tdc_pkg::S_DONE;
        end else begin
          idx_nxt = '0;
          found_nxt = 1'b0;
          state_nxt = tdc_pkg::S_SCAN;
        end
      end
      tdc_pkg::S_SCAN: begin
        rd_addr = idx_r;
        state_nxt = tdc_pkg::S_SCAN_WAIT;
      end
      tdc_pkg::S_SCAN_WAIT: begin
        if (idx_r != '0 && TW'(tof_r) < rd_time && TW'(tof_r) > prev_t_r) begin
          best_nxt = idx_r;
          found_nxt = 1'b1;
        end
        prev_t_nxt = rd_time;
        if (idx_r == IW'(tdc_pkg::TABLE_ENTRIES - 1)) begin
          if (found_nxt) begin
            idx_nxt = best_nxt - IW'(1);
            phase_nxt = 1'b0;
            state_nxt = tdc_pkg::S_FETCH;
          end else begin
            code_nxt = tdc_pkg::RC_OUTSIDE;
            state_nxt = tdc_pkg::S_DONE;
          end
        end else begin
          idx_nxt = idx_r + IW'(1);
          state_nxt = tdc_pkg::S_SCAN;
        end
      end
      tdc_pkg::S_FETCH: begin
        rd_addr = idx_r;
        state_nxt = tdc_pkg::S_FETCH_WAIT;
      end
      tdc_pkg::S_FETCH_WAIT: begin
        if (!phase_r) begin
          tlo_nxt = rd_time;
          dlo_nxt = rd_dist;
          idx_nxt = best_r;
          phase_nxt = 1'b1;
          state_nxt = tdc_pkg::S_FETCH;
        end else begin
          thi_nxt = rd_time;
          dhi_nxt = rd_dist;
          state_nxt = tdc_pkg::S_PROD;
        end
      end
      tdc_pkg::S_PROD: begin
        prod_nxt = iprod[47:0];
        phase_nxt = 1'b0;
        state_nxt = tdc_pkg::S_DIV2;
      end
      tdc_pkg::S_DIV2: begin
        if (!phase_r) begin
          dreq.start = 1'b1;
          dreq.dividend = QW'(iprod);
          dreq.divisor = 32'(tspan);
          phase_nxt = 1'b1;
        end else if (drsp.done) begin
          dist_nxt = 25'(dlo_r) + drsp.quotient[24:0];
          seg_nxt = best_r;
          state_nxt = tdc_pkg::S_DONE;
        end
      end
      tdc_pkg::S_DONE: begin
        valid_nxt = 1'b1;
        state_nxt = tdc_pkg::S_IDLE;
      end
      default: state_nxt = tdc_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= tdc_pkg::S_IDLE;
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
    tcount_r <= tcount_nxt;
    divisor_r <= divisor_nxt;
    prod_r <= prod_nxt;
    tof_r <= tof_nxt;
    idx_r <= idx_nxt;
    best_r <= best_nxt;
    found_r <= found_nxt;
    prev_t_r <= prev_t_nxt;
    tlo_r <= tlo_nxt;
    thi_r <= thi_nxt;
    dlo_r <= dlo_nxt;
    dhi_r <= dhi_nxt;
    code_r <= code_nxt;
    dist_r <= dist_nxt;
    seg_r <= seg_nxt;
  end

  assign busy = (state_r != tdc_pkg::S_IDLE) || valid_r;
  assign out_valid = valid_r;
  assign out_result_code = code_r;
  assign out_distance_mm = dist_r;
  assign out_segment = seg_r;
  assign out_flight_time_ps = tof_r;
endmodule
`default_nettype wire

// ----- rtl/core/tdc_divider.sv -----
// restoring divider, one quotient bit per cycle
`default_nettype none
module tdc_divider (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire tdc_pkg::div_req_t req,
  output tdc_pkg::div_rsp_t rsp
);
  localparam int unsigned QW = tdc_pkg::QUOT_W;
  logic [QW-1:0] quo_r, quo_nxt;
  logic [32:0] rem_r, rem_nxt;
  logic [31:0] dvs_r, dvs_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic busy_r, busy_nxt, done_r, done_nxt;
  logic [32:0] trial;

  always_comb begin
    quo_nxt = quo_r;
    rem_nxt = rem_r;
    dvs_nxt = dvs_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r[31:0], quo_r[QW-1]};
    if (req.start) begin
      quo_nxt = req.dividend;
      rem_nxt = '0;
      dvs_nxt = req.divisor;
      cnt_nxt = 6'(QW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (trial >= {1'b0, dvs_r}) begin
        rem_nxt = trial - {1'b0, dvs_r};
        quo_nxt = {quo_r[QW-2:0], 1'b1};
      end else begin
        rem_nxt = trial;
        quo_nxt = {quo_r[QW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign rsp.done = done_r;
  assign rsp.quotient = quo_r;
endmodule
`default_nettype wire

// ----- rtl/core/tdc_table_ram.sv -----
// calibration table memory, one write and one registered read port
`default_nettype none
module tdc_table_ram (
  input  wire logic clk,
  input  wire logic wr_en,
  input  wire logic [tdc_pkg::IDX_W-1:0] wr_addr,
  input  wire logic [tdc_pkg::TIME_W-1:0] wr_time,
  input  wire logic [tdc_pkg::DIST_W-1:0] wr_dist,
  input  wire logic [tdc_pkg::IDX_W-1:0] rd_addr,
  output logic [tdc_pkg::TIME_W-1:0] rd_time,
  output logic [tdc_pkg::DIST_W-1:0] rd_dist
);
  logic [tdc_pkg::TIME_W+tdc_pkg::DIST_W-1:0] mem [tdc_pkg::TABLE_ENTRIES];
  logic [tdc_pkg::TIME_W+tdc_pkg::DIST_W-1:0] rd_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= {wr_time, wr_dist};
    end
    rd_r <= mem[rd_addr];
  end

  assign rd_time = rd_r[tdc_pkg::TIME_W+tdc_pkg::DIST_W-1:tdc_pkg::DIST_W];
  assign rd_dist = rd_r[tdc_pkg::DIST_W-1:0];
endmodule
`default_nettype wire
